@@ rtl/halving_average_with_sorted_insert_defines.svh @@
// Assertion macros for the halving average / sorted insert block.
// Used by the top level only; no other dependencies.
`ifndef HALVING_AVERAGE_WITH_SORTED_INSERT_DEFINES_SVH
`define HALVING_AVERAGE_WITH_SORTED_INSERT_DEFINES_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define HSI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HSI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hsi_pkg.sv @@
// Shared types and constants for the halving average / sorted insert block.
// No dependencies.
package hsi_pkg;

   localparam int CAPACITY = 64;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   localparam int VALUE_W       = 64;
   localparam int IDX_W         = 6;
   localparam int ENTRY_COUNT_W = 7;

   // read select tree: groups of eight cells, one register stage between
   localparam int READ_SLOTS  = 2 ** IDX_W;
   localparam int READ_GROUP  = 8;
   localparam int READ_GROUPS = READ_SLOTS / READ_GROUP;
   localparam int LANE_W      = $clog2(READ_GROUP);
   localparam int GRP_W       = $clog2(READ_GROUPS);

   localparam logic CMD_STEP = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [VALUE_W-1:0] step_input;
      logic [VALUE_W-1:0] new_weight;
      logic [VALUE_W-1:0] new_payload;
      logic [IDX_W-1:0]   read_index;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0]       running_value;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic [VALUE_W-1:0]       read_weight;
      logic [VALUE_W-1:0]       read_payload;
      logic                     read_hit;
      logic                     dropped;
   } rsp_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] weight;
      logic [VALUE_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic update;   // insert step this cycle
      logic valid;    // cell lies below the fill count
   } cell_ctl_type;

endpackage

@@ rtl/hsi_cell.sv @@
// One cell of the sorted list: holds a weight/payload pair.
// Depends on hsi_pkg.
module hsi_cell
   import hsi_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    new_entry,
   input  entry_type    prev_entry,
   input  logic         prev_keep,
   output entry_type    entry,
   output logic         keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // keep: valid and not below the new weight, so the new pair lands after us
   always_comb begin
      keep     = ctl.valid && (entry_ff.weight >= new_entry.weight);
      entry_in = entry_ff;
      if (ctl.update && !keep) begin
         entry_in = prev_keep ? new_entry : prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ rtl/hsi_read_tree.sv @@
// Two-level registered select over the cells for the read command.
// Depends on hsi_pkg.
module hsi_read_tree
   import hsi_pkg::*;
(
   input  logic             clock,
   input  logic             capture,
   input  logic [IDX_W-1:0] index,
   input  entry_type        slots [READ_SLOTS],
   output entry_type        selected
);

   entry_type          grp_ff [READ_GROUPS];
   entry_type          grp_in [READ_GROUPS];
   logic [GRP_W-1:0]   sel_ff;
   logic [GRP_W-1:0]   sel_in;
   logic [LANE_W-1:0]  lane;

   assign lane = index[LANE_W-1:0];

   always_comb begin
      sel_in = capture ? index[IDX_W-1:LANE_W] : sel_ff;
      for (int g = 0; g < READ_GROUPS; g++) begin
         grp_in[g] = capture ? slots[{GRP_W'(g), lane}] : grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      for (int g = 0; g < READ_GROUPS; g++) begin
         grp_ff[g] <= grp_in[g];
      end
   end

   assign selected = grp_ff[sel_ff];

endmodule

@@ rtl/halving_average_with_sorted_insert.sv @@
// Top level: halving running average plus a bounded list sorted by weight.
// Depends on hsi_pkg, hsi_cell, hsi_read_tree and the assertion macro header.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+---------------------------------------
//  request  | start, busy, req_data     | taken at an edge with start & !busy
//  response | rsp_strobe, rsp_data      | one cycle wide, receiver cannot stall
//
// A step item passes through the EXEC state, in which every cell compares its
// weight with the new one and shifts, then the response register. A read item
// also passes through the READ state: the select tree over the cells has a
// register between its group and final levels. busy drops with the strobe, so
// the next item may be taken in the strobe cycle. Synchronous reset empties the
// list (count to zero) and clears the running value.
`include "halving_average_with_sorted_insert_defines.svh"

module halving_average_with_sorted_insert
   import hsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_data,
   output logic         rsp_strobe,
   output rsp_item_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ
   } state_type;

   state_type            state_ff, state_in;
   req_item_type         req_ff, req_in;
   logic [VALUE_W-1:0]   avg_ff, avg_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   rsp_item_type         rsp_ff, rsp_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;

   logic                 accept;
   logic                 do_step;
   logic                 full;
   logic [VALUE_W-1:0]   sum;
   logic [31:0]          count_wide;
   logic                 hit;

   cell_ctl_type         cell_ctl [CAPACITY];
   entry_type            cell_entry [CAPACITY];
   logic                 cell_keep [CAPACITY];
   entry_type            slots [READ_SLOTS];
   entry_type            rd_entry;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign do_step = (state_ff == ST_EXEC) && (req_ff.cmd == CMD_STEP);
   assign full    = (count_ff == COUNT_W'(CAPACITY));

   // ---- cell chain: cell 0 holds the largest weight ----
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_ctl[i].update = do_step;
      assign cell_ctl[i].valid  = (COUNT_W'(i) < count_ff);
      if (i == 0) begin : g_head
         hsi_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[i]),
            .new_entry  ({req_ff.new_weight, req_ff.new_payload}),
            .prev_entry ({req_ff.new_weight, req_ff.new_payload}),
            .prev_keep  (1'b1),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i])
         );
      end else begin : g_body
         hsi_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[i]),
            .new_entry  ({req_ff.new_weight, req_ff.new_payload}),
            .prev_entry (cell_entry[i-1]),
            .prev_keep  (cell_keep[i-1]),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i])
         );
      end
   end

   // ---- read path: index space is fixed by the 6-bit read index ----
   for (genvar s = 0; s < READ_SLOTS; s++) begin : g_slot
      if (s < CAPACITY) begin : g_used
         assign slots[s] = cell_entry[s];
      end else begin : g_pad
         assign slots[s] = '0;
      end
   end

   hsi_read_tree u_read_tree (
      .clock    (clock),
      .capture  ((state_ff == ST_EXEC) && (req_ff.cmd == CMD_READ)),
      .index    (req_ff.read_index),
      .slots    (slots),
      .selected (rd_entry)
   );

   // ---- next-state logic ----
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      avg_in        = avg_ff;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;

      // odd sum rounds up; the sum may wrap, but sum>>1 leaves room for the round-up
      sum        = avg_ff + req_ff.step_input;
      count_wide = 32'(count_ff);
      hit        = (32'(req_ff.read_index) < count_wide) &&
                   (32'(req_ff.read_index) < 32'(CAPACITY));

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.cmd == CMD_STEP) begin
               avg_in   = {1'b0, sum[VALUE_W-1:1]} + VALUE_W'(sum[0]);
               count_in = full ? count_ff : count_ff + COUNT_W'(1);
               count_wide = 32'(count_in);
               rsp_in.running_value = avg_in;
               rsp_in.entry_count   = count_wide[ENTRY_COUNT_W-1:0];
               rsp_in.read_weight   = '0;
               rsp_in.read_payload  = '0;
               rsp_in.read_hit      = 1'b0;
               rsp_in.dropped       = full;   // tail, or the new pair itself
               rsp_strobe_in        = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rsp_in.running_value = avg_ff;
            rsp_in.entry_count   = count_wide[ENTRY_COUNT_W-1:0];
            rsp_in.read_weight   = hit ? rd_entry.weight  : '0;
            rsp_in.read_payload  = hit ? rd_entry.payload : '0;
            rsp_in.read_hit      = hit;
            rsp_in.dropped       = 1'b0;
            rsp_strobe_in        = 1'b1;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         avg_ff        <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         avg_ff        <= avg_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // ---- checks ----
   `HSI_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= COUNT_W'(CAPACITY), "count past capacity")
   `HSI_ASSERT_NXT(a_accept_busy, accept, busy, "not busy after taking an item")
   `HSI_ASSERT_IMP(a_drop_full, rsp_strobe_ff && rsp_ff.dropped, full, "drop on a list not full")
   `HSI_ASSERT_IMP(a_hit_on_read, rsp_strobe_ff && rsp_ff.read_hit, $past(state_ff) == ST_READ,
      "read hit outside a read")

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for halving_average_with_sorted_insert: drives step and read items,
// keeps its own copy of the running value and the sorted list, and checks every response.
// Depends on hsi_pkg and the RTL of the block; reads no files.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hsi_pkg::*;

   localparam int RANDOM_ITEMS = 1930;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [VALUE_W-1:0] ALL_ONES = '1;
   localparam logic [VALUE_W-1:0] TOP_BIT  = {1'b1, {(VALUE_W-1){1'b0}}};

   logic         clock;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_data = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_item_type rsp_data;

   // bench copy of the block state
   logic [VALUE_W-1:0] mirror_value = '0;
   logic [VALUE_W-1:0] mirror_weight [CAPACITY];
   logic [VALUE_W-1:0] mirror_payload [CAPACITY];
   int                 mirror_count = 0;

   // responses still owed by the block, oldest first
   rsp_item_type pending_rsp [$];

   int fail_count  = 0;
   int step_count  = 0;
   int read_count  = 0;
   int drop_count  = 0;
   int hit_count   = 0;
   int cycle_count = 0;
   int burst_left  = 0;

   halving_average_with_sorted_insert dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs or never answers
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Applies one item to the bench copy of the state and returns the response it
   // should produce. Step: halve the wrapping sum rounding up, then insert the pair
   // after all entries of equal or greater weight; on a full list the tail falls
   // off, and if the new pair would itself be the tail the list stays unchanged.
   function automatic rsp_item_type apply_item(input req_item_type item);
      rsp_item_type       rsp;
      logic [VALUE_W-1:0] sum;
      int                 pos;
      int                 last;
      int                 i;
      bit                 full;
      rsp = '0;
      if (item.cmd == CMD_STEP) begin
         step_count++;
         sum = mirror_value + item.step_input;
         mirror_value = (sum >> 1) + {{(VALUE_W-1){1'b0}}, sum[0]};
         pos = 0;
         while (pos < mirror_count && mirror_weight[pos] >= item.new_weight) pos++;
         full = (mirror_count == CAPACITY);
         if (full && pos >= CAPACITY) begin
            rsp.dropped = 1'b1;
         end else begin
            last = full ? CAPACITY - 1 : mirror_count;
            for (i = last; i > pos; i--) begin
               mirror_weight[i]  = mirror_weight[i-1];
               mirror_payload[i] = mirror_payload[i-1];
            end
            mirror_weight[pos]  = item.new_weight;
            mirror_payload[pos] = item.new_payload;
            if (full) rsp.dropped = 1'b1;
            else mirror_count++;
         end
         if (rsp.dropped) drop_count++;
      end else begin
         read_count++;
         // index past the fill count: a miss with zero data
         if (int'(item.read_index) < mirror_count) begin
            rsp.read_weight  = mirror_weight[item.read_index];
            rsp.read_payload = mirror_payload[item.read_index];
            rsp.read_hit     = 1'b1;
            hit_count++;
         end
      end
      rsp.running_value = mirror_value;
      rsp.entry_count   = mirror_count[ENTRY_COUNT_W-1:0];
      return rsp;
   endfunction

   function automatic logic [VALUE_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // unused fields of each command carry random bits, so every input bit toggles
   function automatic req_item_type step_item(input logic [VALUE_W-1:0] addend,
                                              input logic [VALUE_W-1:0] weight,
                                              input logic [VALUE_W-1:0] payload);
      req_item_type item;
      item.cmd         = CMD_STEP;
      item.step_input  = addend;
      item.new_weight  = weight;
      item.new_payload = payload;
      item.read_index  = IDX_W'($urandom_range(0, READ_SLOTS - 1));
      return item;
   endfunction

   function automatic req_item_type read_item(input int index);
      req_item_type item;
      item.cmd         = CMD_READ;
      item.step_input  = rand_word();
      item.new_weight  = rand_word();
      item.new_payload = rand_word();
      item.read_index  = IDX_W'(index);
      return item;
   endfunction

   // Holds start high until the block takes the item. busy is sampled at the
   // falling edge, so the accepting rising edge is known without a race.
   task automatic send_item(input req_item_type item);
      start    <= 1'b1;
      req_data <= item;
      do @(negedge clock); while (busy !== 1'b0);
      pending_rsp.push_back(apply_item(item));
      @(posedge clock);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // sender works in bursts; now and then a long one with no idling at all
   task automatic issue(input req_item_type item);
      if (burst_left == 0) begin
         idle_for($urandom_range(0, 6));
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      send_item(item);
   endtask

   task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   // Response checker: samples the strobe and the response data at the falling edge.
   always @(negedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $error("response with none outstanding: %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("running_value", want.running_value, rsp_data.running_value);
            check_field("entry_count", VALUE_W'(want.entry_count),
                        VALUE_W'(rsp_data.entry_count));
            check_field("read_weight", want.read_weight, rsp_data.read_weight);
            check_field("read_payload", want.read_payload, rsp_data.read_payload);
            check_field("read_hit", VALUE_W'(want.read_hit), VALUE_W'(rsp_data.read_hit));
            check_field("dropped", VALUE_W'(want.dropped), VALUE_W'(rsp_data.dropped));
         end
      end
   end

   // reads on the empty list, at both ends of the index range
   task automatic test_empty_reads();
      issue(read_item(0));
      issue(read_item(READ_SLOTS - 1));
   endtask

   // all-ones sum rounds up to the top bit alone; wrapping sum; odd and even sums
   task automatic test_halving_rounding();
      issue(step_item(ALL_ONES, 64'd5, 64'hA5A5_0000_0000_0001));
      issue(step_item(TOP_BIT, ALL_ONES, 64'hA5A5_0000_0000_0002));
      issue(step_item(64'd1, '0, 64'hA5A5_0000_0000_0003));
      issue(step_item(64'd2, 64'd5, 64'hA5A5_0000_0000_0004));
   endtask

   // equal weights go behind the ones already held; then read every entry,
   // one past the count and the last index
   task automatic test_equal_weight_order();
      int idx;
      issue(step_item(rand_word(), 64'd5, 64'h5A5A_0000_0000_0005));
      issue(step_item(rand_word(), ALL_ONES, 64'h5A5A_0000_0000_0006));
      issue(step_item(rand_word(), '0, 64'h5A5A_0000_0000_0007));
      issue(step_item(rand_word(), 64'd5, 64'h5A5A_0000_0000_0008));
      for (idx = 0; idx <= mirror_count; idx++) issue(read_item(idx));
      issue(read_item(READ_SLOTS - 1));
   endtask

   // Mixed traffic. Weights lean towards zero and small values so that ties and
   // full-list drops of the new pair itself are common; the list fills early
   // and stays full, so every later step loses an entry.
   task automatic test_random_traffic(input int items);
      int                 n;
      int                 idx;
      logic [VALUE_W-1:0] addend;
      logic [VALUE_W-1:0] weight;
      for (n = 0; n < items; n++) begin
         if ($urandom_range(0, 99) < 55) begin
            case ($urandom_range(0, 9))
               0: addend = ALL_ONES;
               1: addend = '0;
               2: addend = TOP_BIT;
               default: addend = rand_word();
            endcase
            case ($urandom_range(0, 9))
               0: weight = '0;
               1: weight = ALL_ONES;
               2, 3, 4: weight = VALUE_W'($urandom_range(0, 7));
               default: weight = rand_word();
            endcase
            issue(step_item(addend, weight, rand_word()));
         end else begin
            case ($urandom_range(0, 7))
               0: idx = mirror_count < READ_SLOTS ? mirror_count : 0;
               1: idx = mirror_count > 0 ? mirror_count - 1 : READ_SLOTS - 1;
               default: idx = $urandom_range(0, READ_SLOTS - 1);
            endcase
            issue(read_item(idx));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_reads();
      test_halving_rounding();
      test_equal_weight_order();
      test_random_traffic(RANDOM_ITEMS);

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d steps (%0d lost an entry off a full list) and %0d reads",
               step_count, drop_count, read_count);
      $display("(%0d reads found a stored entry); %0d mismatches.", hit_count, fail_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
